FILE: sv/sal_pkg.sv
package sal_pkg;

  localparam int ATLAS_WIDTH = 256;
  localparam int ATLAS_HEIGHT = 256;

  localparam int COL_W = $clog2(ATLAS_WIDTH);
  localparam int HGT_W = $clog2(ATLAS_HEIGHT + 1);
  localparam int RECT_W = 9;
  localparam int SUM_W = ((HGT_W > RECT_W) ? HGT_W : RECT_W) + 1;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
  } sal_req_t;

  typedef struct packed {
    logic       placed;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [8:0] used_height;
  } sal_res_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LOAD  = 3'd1,
    CELL_WIN   = 3'd2,
    CELL_SCAN  = 3'd3,
    CELL_WRITE = 3'd4,
    CELL_CLEAR = 3'd5
  } sal_cell_op_t;

  typedef struct packed {
    sal_cell_op_t     op;
    logic [COL_W-1:0] x_lo;
    logic [COL_W:0]   x_hi;
    logic [HGT_W-1:0] value;
  } sal_cell_ctl_t;

endpackage

FILE: sv/sal_cell.sv
module sal_cell import sal_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  sal_cell_ctl_t    ctl,
  input  logic [COL_W-1:0] index,
  input  logic [HGT_W-1:0] s_in,
  input  logic [HGT_W-1:0] acc_in,
  output logic [HGT_W-1:0] s_out,
  output logic [HGT_W-1:0] acc_out
);

  logic [HGT_W-1:0] fill;
  logic [HGT_W-1:0] s;
  logic [HGT_W-1:0] acc;
  logic             in_range;

  assign in_range = (index >= ctl.x_lo) && ({1'b0, index} < ctl.x_hi);
  assign s_out = s;
  assign acc_out = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      if (ctl.op == CELL_CLEAR) begin
        fill <= '0;
      end else if (ctl.op == CELL_WRITE && in_range) begin
        fill <= ctl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_LOAD: begin
        s <= fill;
        acc <= fill;
      end
      CELL_WIN: begin
        s <= s_in;
        if (s_in > acc) begin
          acc <= s_in;
        end
      end
      CELL_SCAN: begin
        acc <= acc_in;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/sal_ctrl.sv
module sal_ctrl import sal_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sal_req_t         req,
  input  logic [HGT_W-1:0] acc_head,
  output logic             busy,
  output logic             done,
  output sal_res_t         result,
  output sal_cell_ctl_t    ctl
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WIN  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t            state;
  logic [COL_W-1:0]  cnt;
  logic [COL_W-1:0]  idx;
  logic [COL_W-1:0]  last;
  logic [HGT_W-1:0]  best;
  logic [COL_W-1:0]  bx;
  logic [COL_W-1:0]  w_reg;
  logic [RECT_W-1:0] h_reg;
  logic              alloc_mode;

  logic              accept;
  logic              w_ok;
  logic              size_ok;
  logic [COL_W-1:0]  w_lo;
  logic [SUM_W-1:0]  top_sum;
  logic              fit;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign w_lo = req.rect_width[COL_W-1:0];
  assign w_ok = (req.rect_width != '0) && (req.rect_width < ATLAS_WIDTH);
  assign size_ok = w_ok && (req.rect_height != '0);
  assign top_sum = SUM_W'(best) + SUM_W'(h_reg);
  assign fit = (best < ATLAS_HEIGHT) && (top_sum <= ATLAS_HEIGHT);

  always_comb begin
    ctl.op = CELL_HOLD;
    ctl.x_lo = bx;
    ctl.x_hi = {1'b0, bx} + {1'b0, w_reg};
    ctl.value = HGT_W'(top_sum);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.opcode)
            OP_ALLOC: begin
              if (size_ok) begin
                ctl.op = CELL_LOAD;
              end
            end
            OP_CLEAR: ctl.op = CELL_CLEAR;
            OP_QUERY: ctl.op = CELL_LOAD;
            default:  ctl.op = CELL_HOLD;
          endcase
        end
      end
      ST_WIN:  ctl.op = CELL_WIN;
      ST_SCAN: ctl.op = CELL_SCAN;
      ST_UPD: begin
        if (alloc_mode && fit) begin
          ctl.op = CELL_WRITE;
        end
      end
      default: ctl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.opcode == OP_ALLOC && size_ok) begin
              state <= (w_lo == COL_W'(1)) ? ST_SCAN : ST_WIN;
            end else if (req.opcode == OP_QUERY) begin
              state <= ST_SCAN;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_WIN: begin
          if (cnt == COL_W'(1)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == last) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          alloc_mode <= (req.opcode == OP_ALLOC);
          w_reg <= w_lo;
          h_reg <= req.rect_height;
          cnt <= w_lo - COL_W'(1);
          idx <= '0;
          bx <= '0;
          result <= '0;
          if (req.opcode == OP_ALLOC) begin
            best <= HGT_W'(ATLAS_HEIGHT);
            last <= COL_W'(ATLAS_WIDTH - 1) - w_lo;
          end else begin
            best <= '0;
            last <= COL_W'(ATLAS_WIDTH - 1);
          end
        end
      end
      ST_WIN: begin
        cnt <= cnt - COL_W'(1);
      end
      ST_SCAN: begin
        idx <= idx + COL_W'(1);
        if (alloc_mode) begin
          if (acc_head < best) begin
            best <= acc_head;
            bx <= idx;
          end
        end else if (acc_head > best) begin
          best <= acc_head;
        end
      end
      ST_UPD: begin
        if (!alloc_mode) begin
          result <= '{placed: 1'b0, x_pos: 8'd0, y_pos: 8'd0, used_height: 9'(best)};
        end else if (fit) begin
          result <= '{placed: 1'b1, x_pos: 8'(bx), y_pos: 8'(best), used_height: 9'd0};
        end else begin
          result <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_upd_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |=> done && state == ST_IDLE)
    else $error("scan end did not produce a result");

  a_placed_no_height: assert property (@(posedge clk) disable iff (rst)
    done && result.placed |-> result.used_height == '0)
    else $error("placed result carries a used height");

  a_win_only_alloc: assert property (@(posedge clk) disable iff (rst)
    state == ST_WIN |-> alloc_mode)
    else $error("window steps outside an allocate request");

  a_clear_immediate: assert property (@(posedge clk) disable iff (rst)
    accept && req.opcode == OP_CLEAR |=> done && state == ST_IDLE && !result.placed)
    else $error("clear request did not complete at once");

endmodule

FILE: sv/skyline_atlas_allocator.sv
// Channel   Handshake                   Payload
// request   start, accepted when !busy  req    (opcode, rect_width, rect_height)
// result    done, one-cycle strobe      result (placed, x_pos, y_pos, used_height)
//
// An allocate runs window steps (none for width 1), then a scan of candidate x positions and one
// update step, with the result strobed on the cycle after the update.
// A query scans every column and then updates; clear, unused opcodes and rejected sizes answer next cycle.
// Reset zeroes every column height at once and needs no sweep.
// The receiver cannot stall; busy holds off new requests while a scan runs.
module skyline_atlas_allocator import sal_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  sal_req_t req,
  output logic     busy,
  output logic     done,
  output sal_res_t result
);

  sal_cell_ctl_t    ctl;
  logic [HGT_W-1:0] s_link [ATLAS_WIDTH+1];
  logic [HGT_W-1:0] acc_link [ATLAS_WIDTH+1];

  assign s_link[ATLAS_WIDTH] = '0;
  assign acc_link[ATLAS_WIDTH] = '0;

  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .acc_head (acc_link[0]),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < ATLAS_WIDTH; i++) begin : g_cell
    sal_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .index   (COL_W'(i)),
      .s_in    (s_link[i+1]),
      .acc_in  (acc_link[i+1]),
      .s_out   (s_link[i]),
      .acc_out (acc_link[i])
    );
  end

endmodule
